// ----- rtl/hdlc_tx_pkg.sv -----
// Shared constants for the HDLC frame transmitter: line flag, stuffing run,
// CRC-16/X.25 polynomial and the output word format. No dependencies.
`default_nettype none

package hdlc_tx_pkg;

  localparam int unsigned DATA_W       = 8;
  localparam int unsigned OUT_WORD_W   = 32;
  localparam int unsigned BYTE_COUNT_W = 3;
  localparam int unsigned WORD_BITS_DEF = 32;

  localparam logic [7:0]  FLAG_BYTE    = 8'h7E;
  localparam logic [2:0]  STUFF_RUN    = 3'd5;
  localparam logic [15:0] CRC_POLY     = 16'h8408;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [2:0]  RESULT_LIMIT = 3'd4;

endpackage : hdlc_tx_pkg

`default_nettype wire

// ----- rtl/hdlc_tx_if.sv -----
// Valid/ready channel interfaces for the HDLC frame transmitter.
// Depends on hdlc_tx_pkg for the payload widths.
`default_nettype none

interface hdlc_tx_in_if;
  logic                              valid;
  logic                              ready;
  logic [hdlc_tx_pkg::DATA_W-1:0]    data_byte;
  logic                              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface : hdlc_tx_in_if

interface hdlc_tx_out_if;
  logic                                   valid;
  logic                                   ready;
  logic [hdlc_tx_pkg::OUT_WORD_W-1:0]     word;
  logic [hdlc_tx_pkg::BYTE_COUNT_W-1:0]   byte_count;
  logic                                   frame_end;

  modport source (output valid, output word, output byte_count, output frame_end,
                  input ready);
  modport sink   (input valid, input word, input byte_count, input frame_end,
                  output ready);
endinterface : hdlc_tx_out_if

`default_nettype wire

// ----- rtl/hdlc_frame_transmitter.sv -----
// HDLC / AX.25 frame transmitter: bit-serial stuffing, CRC-16/X.25 and packing.
// Depends on hdlc_tx_pkg and the channel interfaces in hdlc_tx_if.
//
// Usage: in_i carries one frame byte per word, last_byte set on the final
// byte. out_o carries packed line bits, first bit in bit 0, with the
// number of valid low bytes in byte_count and frame_end on a frame's last word.
// The first byte of a frame yields an opening flag word 0x7E (one byte).
// Bits go out LSB first with a zero stuffed after five ones; after the last
// byte come the FCS (16 bits, stuffed) and an unstuffed closing flag, and the
// final partial word is flushed.
// Timing: one line bit per cycle through the serializer while it is not
// stalled. A middle byte goes from its accept to the next through the
// accept, 8 data bits, up to 2 stuffed zeros, a phase change and a flush;
// the first byte adds the flag state; the last byte adds the FCS (16 bits,
// up to 4 stuffed zeros), the closing flag and the final word.
// The next byte is accepted once the serializer has finished the previous
// one; a finished word waits in a holding stage and the output register.
// Reset: no frame in progress, packer empty, CRC at all ones.
// Receiver stall: the serializer stops when a new word is ready while the
// holding stage is full and the output register is full and not taken.
`default_nettype none

module hdlc_frame_transmitter #(
  parameter int unsigned WORD_BITS = hdlc_tx_pkg::WORD_BITS_DEF
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  hdlc_tx_in_if.sink   in_i,
  hdlc_tx_out_if.source out_o
);

  localparam int unsigned FillW = $clog2(WORD_BITS);
  localparam int unsigned OutW  = hdlc_tx_pkg::OUT_WORD_W;
  localparam int unsigned BcW   = hdlc_tx_pkg::BYTE_COUNT_W;
  localparam logic [FillW-1:0] FillLast = FillW'(WORD_BITS - 1);
  localparam logic [BcW-1:0]   FullBytes = BcW'(WORD_BITS / 8);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StOpen  = 3'd1;
  localparam logic [2:0] StData  = 3'd2;
  localparam logic [2:0] StFcs   = 3'd3;
  localparam logic [2:0] StClose = 3'd4;
  localparam logic [2:0] StPart  = 3'd5;
  localparam logic [2:0] StFlush = 3'd6;

  logic [2:0]           state_q, state_d;
  logic                 in_frame_q, in_frame_d;
  logic                 last_q, last_d;
  logic [15:0]          sh_q, sh_d;
  logic [4:0]           cnt_q, cnt_d;
  logic [15:0]          crc_q, crc_d;
  logic [2:0]           ones_q, ones_d;
  logic                 stuff_q, stuff_d;
  logic [WORD_BITS-1:0] acc_q, acc_d;
  logic [FillW-1:0]     fill_q, fill_d;
  logic [2:0]           rcnt_q, rcnt_d;
  logic                 hold_v_q, hold_v_d;
  logic [OutW-1:0]      hold_word_q, hold_word_d;
  logic [BcW-1:0]       hold_bytes_q, hold_bytes_d;
  logic                 out_v_q, out_v_d;
  logic [OutW-1:0]      out_word_q, out_word_d;
  logic [BcW-1:0]       out_bytes_q, out_bytes_d;
  logic                 out_end_q, out_end_d;

  // serializer step, independent of stall
  logic                 push, pbit, stuffed, full;
  logic                 gen;
  logic [OutW-1:0]      gen_word;
  logic [BcW-1:0]       gen_bytes;
  logic [WORD_BITS-1:0] acc_set;
  logic [OutW-1:0]      acc_set_out, acc_out;
  logic [FillW+1:0]     part_bytes;
  logic                 out_free, keep, stall;
  logic                 crc_fb;

  always_comb begin
    acc_set = acc_q;
    acc_set[fill_q] = pbit;
  end

  if (WORD_BITS >= OutW) begin : g_wide
    assign acc_set_out = acc_set[OutW-1:0];
    assign acc_out     = acc_q[OutW-1:0];
  end else begin : g_narrow
    assign acc_set_out = {{(OutW-WORD_BITS){1'b0}}, acc_set};
    assign acc_out     = {{(OutW-WORD_BITS){1'b0}}, acc_q};
  end

  assign part_bytes = ({2'b00, fill_q} + (FillW+2)'(7)) >> 3;

  always_comb begin
    push      = 1'b0;
    pbit      = 1'b0;
    stuffed   = 1'b0;
    gen       = 1'b0;
    gen_word  = acc_set_out;
    gen_bytes = FullBytes;
    unique case (state_q)
      StOpen: begin
        gen       = 1'b1;
        gen_word  = {{(OutW-8){1'b0}}, hdlc_tx_pkg::FLAG_BYTE};
        gen_bytes = BcW'(1);
      end
      StData, StFcs: begin
        stuffed = 1'b1;
        if (stuff_q) begin
          push = 1'b1;
          pbit = 1'b0;
        end else if (cnt_q != 5'd0) begin
          push = 1'b1;
          pbit = sh_q[0];
        end
      end
      StClose: begin
        if (cnt_q != 5'd0) begin
          push = 1'b1;
          pbit = sh_q[0];
        end
      end
      StPart: begin
        if (fill_q != '0) begin
          gen       = 1'b1;
          gen_word  = acc_out;
          gen_bytes = part_bytes[BcW-1:0];
        end
      end
      default: ;
    endcase
    full = push && (fill_q == FillLast);
    if (full) begin
      gen = 1'b1;
    end
  end

  assign out_free = !out_v_q || out_o.ready;
  assign keep     = gen && (rcnt_q < hdlc_tx_pkg::RESULT_LIMIT);
  assign stall    = keep && hold_v_q && !out_free;
  assign crc_fb   = crc_q[0] ^ sh_q[0];

  always_comb begin
    state_d      = state_q;
    in_frame_d   = in_frame_q;
    last_d       = last_q;
    sh_d         = sh_q;
    cnt_d        = cnt_q;
    crc_d        = crc_q;
    ones_d       = ones_q;
    stuff_d      = stuff_q;
    acc_d        = acc_q;
    fill_d       = fill_q;
    rcnt_d       = rcnt_q;
    hold_v_d     = hold_v_q;
    hold_word_d  = hold_word_q;
    hold_bytes_d = hold_bytes_q;
    out_v_d      = out_v_q && !out_o.ready;
    out_word_d   = out_word_q;
    out_bytes_d  = out_bytes_q;
    out_end_d    = out_end_q;

    if (!stall) begin
      // new word: previous held word moves on, drop beyond the result limit
      if (keep) begin
        rcnt_d       = rcnt_q + 3'd1;
        hold_v_d     = 1'b1;
        hold_word_d  = gen_word;
        hold_bytes_d = gen_bytes;
        if (hold_v_q) begin
          out_v_d     = 1'b1;
          out_word_d  = hold_word_q;
          out_bytes_d = hold_bytes_q;
          out_end_d   = 1'b0;
        end
      end

      if (push) begin
        if (full) begin
          acc_d  = '0;
          fill_d = '0;
        end else begin
          acc_d  = acc_set;
          fill_d = fill_q + FillW'(1);
        end
        if (!(stuffed && stuff_q)) begin
          cnt_d = cnt_q - 5'd1;
          sh_d  = sh_q >> 1;
        end
        if (state_q == StData && !stuff_q) begin
          crc_d = (crc_q >> 1) ^ (crc_fb ? hdlc_tx_pkg::CRC_POLY : 16'h0000);
        end
        if (stuffed) begin
          if (stuff_q) begin
            stuff_d = 1'b0;
            ones_d  = 3'd0;
          end else if (pbit) begin
            if (ones_q + 3'd1 == hdlc_tx_pkg::STUFF_RUN) begin
              stuff_d = 1'b1;
              ones_d  = 3'd0;
            end else begin
              ones_d = ones_q + 3'd1;
            end
          end else begin
            ones_d = 3'd0;
          end
        end
      end

      unique case (state_q)
        StIdle: begin
          if (in_i.valid) begin
            sh_d   = {8'h00, in_i.data_byte};
            cnt_d  = 5'd8;
            last_d = in_i.last_byte;
            rcnt_d = 3'd0;
            if (in_frame_q) begin
              state_d = StData;
            end else begin
              state_d = StOpen;
              crc_d   = hdlc_tx_pkg::CRC_INIT;
              acc_d   = '0;
              fill_d  = '0;
              ones_d  = 3'd0;
              stuff_d = 1'b0;
            end
          end
        end
        StOpen: begin
          in_frame_d = 1'b1;
          state_d    = StData;
        end
        StData: begin
          if (!push) begin
            if (last_q) begin
              state_d = StFcs;
              sh_d    = ~crc_q;
              cnt_d   = 5'd16;
            end else begin
              state_d = StFlush;
            end
          end
        end
        StFcs: begin
          if (!push) begin
            state_d = StClose;
            sh_d    = {8'h00, hdlc_tx_pkg::FLAG_BYTE};
            cnt_d   = 5'd8;
          end
        end
        StClose: begin
          if (!push) begin
            state_d = StPart;
          end
        end
        StPart: begin
          acc_d   = '0;
          fill_d  = '0;
          state_d = StFlush;
        end
        StFlush: begin
          if (hold_v_q) begin
            if (out_free) begin
              out_v_d     = 1'b1;
              out_word_d  = hold_word_q;
              out_bytes_d = hold_bytes_q;
              out_end_d   = last_q;
              hold_v_d    = 1'b0;
              state_d     = StIdle;
            end
          end else begin
            state_d = StIdle;
          end
          if (state_d == StIdle && last_q) begin
            in_frame_d = 1'b0;
            crc_d      = hdlc_tx_pkg::CRC_INIT;
            ones_d     = 3'd0;
            stuff_d    = 1'b0;
          end
        end
        default: state_d = StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      in_frame_q <= 1'b0;
      cnt_q      <= 5'd0;
      crc_q      <= hdlc_tx_pkg::CRC_INIT;
      ones_q     <= 3'd0;
      stuff_q    <= 1'b0;
      acc_q      <= '0;
      fill_q     <= '0;
      rcnt_q     <= 3'd0;
      hold_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      in_frame_q <= in_frame_d;
      cnt_q      <= cnt_d;
      crc_q      <= crc_d;
      ones_q     <= ones_d;
      stuff_q    <= stuff_d;
      acc_q      <= acc_d;
      fill_q     <= fill_d;
      rcnt_q     <= rcnt_d;
      hold_v_q   <= hold_v_d;
      out_v_q    <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q       <= last_d;
    sh_q         <= sh_d;
    hold_word_q  <= hold_word_d;
    hold_bytes_q <= hold_bytes_d;
    out_word_q   <= out_word_d;
    out_bytes_q  <= out_bytes_d;
    out_end_q    <= out_end_d;
  end

  assign in_i.ready       = (state_q == StIdle);
  assign out_o.valid      = out_v_q;
  assign out_o.word       = out_word_q;
  assign out_o.byte_count = out_bytes_q;
  assign out_o.frame_end  = out_end_q;

endmodule : hdlc_frame_transmitter

`default_nettype wire
